// ===== rtl/rtk_pkg.sv =====
// Shared types, constants and arithmetic helpers for the rotation Kalman tracker.
package rtk_pkg;

    // Field widths
    localparam int ANGLE_W = 32;
    localparam int COV_W   = 48;
    localparam int TIME_W  = 48;
    localparam int COUNT_W = 31;
    localparam int IDX_W   = 2;

    // Iterative multiplier: A operand up to 49 bits, B operand 48 bits, 8 bits a step
    localparam int MUL_A_W   = 49;
    localparam int MUL_B_W   = 48;
    localparam int MUL_DIG_W = 8;
    localparam int MUL_STEPS = MUL_B_W / MUL_DIG_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    // Restoring divider: one quotient bit a step
    localparam int DIV_D_W     = COV_W + 1;
    localparam int DIV_PRE     = 8;
    localparam int DIV_STEPS   = COV_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    // Lane sum width: angle plus a correction capped at 2^40
    localparam int CORR_W = 41;
    localparam int SUM_W  = 43;

    localparam logic [COV_W-1:0]   MASK48    = {COV_W{1'b1}};
    localparam logic [COV_W-1:0]   CAP40     = 48'h010000000000;
    localparam logic [5:0]         SH_TIME   = 6'd16;
    localparam logic [5:0]         SH_GAIN   = 6'd40;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register reset values
    localparam logic [COV_W-1:0] PROC_NOISE_RST = 48'd10995116;
    localparam logic [COV_W-1:0] MEAS_NOISE_RST = 48'd10995116278;
    localparam logic [COV_W-1:0] INIT_COV_RST   = 48'd1099511627776;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_PROCESS_NOISE      = 2'd0;
    localparam logic [IDX_W-1:0] REG_MEASURE_NOISE      = 2'd1;
    localparam logic [IDX_W-1:0] REG_INITIAL_COVARIANCE = 2'd2;

    // Lane control and status
    typedef struct packed {
        logic capture;
        logic first;
        logic correct;
    } rtk_lane_ctl_t;

    typedef struct packed {
        logic busy;
    } rtk_lane_sts_t;

    // Shift a product right and clamp it to cap
    function automatic logic [COV_W-1:0] shr_sat(input logic [PROD_W-1:0] p,
                                                 input logic [5:0] sh,
                                                 input logic [COV_W-1:0] cap);
        logic [PROD_W-1:0] w;
        w = p >> sh;
        if (w > PROD_W'(cap))
            return cap;
        return w[COV_W-1:0];
    endfunction

    // Clamp a wide signed value to the 32-bit range
    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(signed'(33'sh07FFFFFFF)))
            return 32'sh7FFFFFFF;
        if (v < SUM_W'(signed'(33'sh180000000)))
            return 32'sh80000000;
        return v[ANGLE_W-1:0];
    endfunction

    // Give a magnitude its sign back
    function automatic logic signed [SUM_W-1:0] sign_apply(input logic [CORR_W-1:0] mag,
                                                           input logic neg);
        logic signed [SUM_W-1:0] e;
        e = signed'(SUM_W'(mag));
        return neg ? -e : e;
    endfunction

endpackage

// ===== rtl/rtk_if.sv =====
// Handshake channel interfaces for measurements, filtered results and register writes.
interface rtk_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rtk_pkg::ANGLE_W-1:0]   meas_x;
    logic signed [rtk_pkg::ANGLE_W-1:0]   meas_y;
    logic signed [rtk_pkg::ANGLE_W-1:0]   meas_z;
    logic [rtk_pkg::TIME_W-1:0]           time_stamp;

    modport source (output valid, meas_x, meas_y, meas_z, time_stamp, input ready);
    modport sink   (input valid, meas_x, meas_y, meas_z, time_stamp, output ready);
endinterface

interface rtk_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rtk_pkg::ANGLE_W-1:0]   filt_x;
    logic signed [rtk_pkg::ANGLE_W-1:0]   filt_y;
    logic signed [rtk_pkg::ANGLE_W-1:0]   filt_z;
    logic [rtk_pkg::COUNT_W-1:0]          seen_count;

    modport source (output valid, filt_x, filt_y, filt_z, seen_count, input ready);
    modport sink   (input valid, filt_x, filt_y, filt_z, seen_count, output ready);
endinterface

interface rtk_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [rtk_pkg::IDX_W-1:0]            index;
    logic [rtk_pkg::COV_W-1:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rtk_mul.sv =====
// Iterative unsigned multiplier, eight bits of the B operand per cycle, MSB first.
module rtk_mul
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rtk_pkg::MUL_A_W-1:0]       a,
    input  logic [rtk_pkg::MUL_B_W-1:0]       b,
    output logic                              done,
    output logic [rtk_pkg::PROD_W-1:0]        prod
);

    logic [rtk_pkg::MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [rtk_pkg::MUL_A_W-1:0]   a_reg, a_next;
    logic [rtk_pkg::MUL_B_W-1:0]   b_reg, b_next;
    logic [rtk_pkg::PROD_W-1:0]    acc_reg, acc_next;

    // Load operands or take one digit step
    always_comb
    begin
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next   = a;
            b_next   = b;
            acc_next = '0;
            cnt_next = rtk_pkg::MUL_CNT_W'(rtk_pkg::MUL_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            acc_next = (acc_reg << rtk_pkg::MUL_DIG_W)
                     + rtk_pkg::PROD_W'(a_reg
                       * b_reg[rtk_pkg::MUL_B_W-1 -: rtk_pkg::MUL_DIG_W]);
            b_next    = b_reg << rtk_pkg::MUL_DIG_W;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == rtk_pkg::MUL_CNT_W'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operands and accumulator
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/rtk_div.sv =====
// Restoring divider forming both gains (n << 40) / d over one shared divisor, saturating.
module rtk_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rtk_pkg::COV_W-1:0]         n0,
    input  logic [rtk_pkg::COV_W-1:0]         n1,
    input  logic [rtk_pkg::DIV_D_W-1:0]       d,
    output logic                              done,
    output logic [rtk_pkg::COV_W-1:0]         q0,
    output logic [rtk_pkg::COV_W-1:0]         q1
);

    localparam int T_W = rtk_pkg::DIV_D_W + 1;
    localparam int C_W = rtk_pkg::DIV_D_W + rtk_pkg::DIV_PRE;

    logic [rtk_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [rtk_pkg::COV_W-1:0]     n0_reg, n0_next, n1_reg, n1_next;
    logic [rtk_pkg::DIV_D_W-1:0]   d_reg, d_next;
    logic [rtk_pkg::DIV_D_W-1:0]   rem0_reg, rem0_next, rem1_reg, rem1_next;
    logic [rtk_pkg::COV_W-1:0]     feed0_reg, feed0_next, feed1_reg, feed1_next;
    logic [rtk_pkg::COV_W-1:0]     quo0_reg, quo0_next, quo1_reg, quo1_next;
    logic [T_W-1:0]                t0, t1;
    logic                          ovf0, ovf1;

    // Trial subtract on both dividends
    always_comb
    begin
        cnt_next   = cnt_reg;
        n0_next    = n0_reg;
        n1_next    = n1_reg;
        d_next     = d_reg;
        rem0_next  = rem0_reg;
        rem1_next  = rem1_reg;
        feed0_next = feed0_reg;
        feed1_next = feed1_reg;
        quo0_next  = quo0_reg;
        quo1_next  = quo1_reg;
        done_next  = 1'b0;
        t0 = {rem0_reg, feed0_reg[rtk_pkg::COV_W-1]};
        t1 = {rem1_reg, feed1_reg[rtk_pkg::COV_W-1]};
        if (start)
        begin
            n0_next    = n0;
            n1_next    = n1;
            d_next     = d;
            rem0_next  = rtk_pkg::DIV_D_W'(n0 >> rtk_pkg::DIV_PRE);
            rem1_next  = rtk_pkg::DIV_D_W'(n1 >> rtk_pkg::DIV_PRE);
            feed0_next = {n0[rtk_pkg::DIV_PRE-1:0], {(rtk_pkg::COV_W-rtk_pkg::DIV_PRE){1'b0}}};
            feed1_next = {n1[rtk_pkg::DIV_PRE-1:0], {(rtk_pkg::COV_W-rtk_pkg::DIV_PRE){1'b0}}};
            quo0_next  = '0;
            quo1_next  = '0;
            cnt_next   = rtk_pkg::DIV_CNT_W'(rtk_pkg::DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            if (t0 >= T_W'(d_reg))
            begin
                rem0_next = rtk_pkg::DIV_D_W'(t0 - T_W'(d_reg));
                quo0_next = {quo0_reg[rtk_pkg::COV_W-2:0], 1'b1};
            end
            else
            begin
                rem0_next = t0[rtk_pkg::DIV_D_W-1:0];
                quo0_next = {quo0_reg[rtk_pkg::COV_W-2:0], 1'b0};
            end
            if (t1 >= T_W'(d_reg))
            begin
                rem1_next = rtk_pkg::DIV_D_W'(t1 - T_W'(d_reg));
                quo1_next = {quo1_reg[rtk_pkg::COV_W-2:0], 1'b1};
            end
            else
            begin
                rem1_next = t1[rtk_pkg::DIV_D_W-1:0];
                quo1_next = {quo1_reg[rtk_pkg::COV_W-2:0], 1'b0};
            end
            feed0_next = feed0_reg << 1;
            feed1_next = feed1_reg << 1;
            cnt_next   = cnt_reg - 1'b1;
            done_next  = (cnt_reg == rtk_pkg::DIV_CNT_W'(1));
        end
    end

    // Quotient no longer fits 48 bits when n >= d * 256
    assign ovf0 = (C_W'(n0_reg) >= {d_reg, {rtk_pkg::DIV_PRE{1'b0}}});
    assign ovf1 = (C_W'(n1_reg) >= {d_reg, {rtk_pkg::DIV_PRE{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n0_reg    <= n0_next;
        n1_reg    <= n1_next;
        d_reg     <= d_next;
        rem0_reg  <= rem0_next;
        rem1_reg  <= rem1_next;
        feed0_reg <= feed0_next;
        feed1_reg <= feed1_next;
        quo0_reg  <= quo0_next;
        quo1_reg  <= quo1_next;
    end

    assign done = done_reg;
    assign q0   = ovf0 ? rtk_pkg::MASK48 : quo0_reg;
    assign q1   = ovf1 ? rtk_pkg::MASK48 : quo1_reg;

endmodule

// ===== rtl/rtk_lane.sv =====
// One axis lane: angle and rate state, prediction and correction on its own multiplier.
module rtk_lane
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rtk_pkg::rtk_lane_ctl_t             ctl,
    input  logic signed [rtk_pkg::ANGLE_W-1:0] meas,
    input  logic [rtk_pkg::TIME_W-1:0]         dt,
    input  logic [rtk_pkg::COV_W-1:0]          k0,
    input  logic [rtk_pkg::COV_W-1:0]          k1,
    output rtk_pkg::rtk_lane_sts_t             sts,
    output logic signed [rtk_pkg::ANGLE_W-1:0] angle
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_PRED = 4'b0010,
        L_CK0  = 4'b0100,
        L_CK1  = 4'b1000
    } lane_state_t;

    lane_state_t                        phase_reg, phase_next;
    logic signed [rtk_pkg::ANGLE_W-1:0] angle_reg, angle_next;
    logic signed [rtk_pkg::ANGLE_W-1:0] rate_reg, rate_next;
    logic signed [rtk_pkg::ANGLE_W-1:0] meas_reg, meas_next;
    logic signed [rtk_pkg::ANGLE_W-1:0] xp_reg, xp_next;
    logic signed [rtk_pkg::ANGLE_W:0]   y_reg, y_next;
    logic [rtk_pkg::COV_W-1:0]          k1_reg, k1_next;

    logic                               mul_start, mul_done;
    logic [rtk_pkg::MUL_A_W-1:0]        mul_a;
    logic [rtk_pkg::MUL_B_W-1:0]        mul_b;
    logic [rtk_pkg::PROD_W-1:0]         mul_prod;
    logic [rtk_pkg::ANGLE_W-1:0]        rate_mag;
    logic [rtk_pkg::ANGLE_W:0]          y_mag;
    logic [rtk_pkg::COV_W-1:0]          corr_time, corr_gain;

    assign rate_mag  = rate_reg[rtk_pkg::ANGLE_W-1] ? rtk_pkg::ANGLE_W'(-rate_reg)
                                                    : rtk_pkg::ANGLE_W'(rate_reg);
    assign y_mag     = y_reg[rtk_pkg::ANGLE_W] ? (~y_reg + 1'b1) : y_reg;
    assign corr_time = rtk_pkg::shr_sat(mul_prod, rtk_pkg::SH_TIME, rtk_pkg::CAP40);
    assign corr_gain = rtk_pkg::shr_sat(mul_prod, rtk_pkg::SH_GAIN, rtk_pkg::CAP40);

    // Sequence predict, then angle and rate corrections
    always_comb
    begin
        phase_next = phase_reg;
        angle_next = angle_reg;
        rate_next  = rate_reg;
        meas_next  = meas_reg;
        xp_next    = xp_reg;
        y_next     = y_reg;
        k1_next    = k1_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (phase_reg)
            L_IDLE:
            begin
                if (ctl.first)
                begin
                    angle_next = meas;
                    rate_next  = '0;
                end
                else if (ctl.capture)
                begin
                    meas_next  = meas;
                    mul_start  = 1'b1;
                    mul_a      = rtk_pkg::MUL_A_W'(rate_mag);
                    mul_b      = dt;
                    phase_next = L_PRED;
                end
                else if (ctl.correct)
                begin
                    k1_next    = k1;
                    mul_start  = 1'b1;
                    mul_a      = rtk_pkg::MUL_A_W'(y_mag);
                    mul_b      = k0;
                    phase_next = L_CK0;
                end
            end
            L_PRED:
            begin
                if (mul_done)
                begin
                    xp_next = rtk_pkg::sat32(rtk_pkg::SUM_W'(angle_reg)
                            + rtk_pkg::sign_apply(corr_time[rtk_pkg::CORR_W-1:0],
                                                  rate_reg[rtk_pkg::ANGLE_W-1]));
                    y_next  = (rtk_pkg::ANGLE_W+1)'(meas_reg)
                            - (rtk_pkg::ANGLE_W+1)'(xp_next);
                    phase_next = L_IDLE;
                end
            end
            L_CK0:
            begin
                if (mul_done)
                begin
                    angle_next = rtk_pkg::sat32(rtk_pkg::SUM_W'(xp_reg)
                               + rtk_pkg::sign_apply(corr_gain[rtk_pkg::CORR_W-1:0],
                                                     y_reg[rtk_pkg::ANGLE_W]));
                    mul_start  = 1'b1;
                    mul_a      = rtk_pkg::MUL_A_W'(y_mag);
                    mul_b      = k1_reg;
                    phase_next = L_CK1;
                end
            end
            L_CK1:
            begin
                if (mul_done)
                begin
                    rate_next  = rtk_pkg::sat32(rtk_pkg::SUM_W'(rate_reg)
                               + rtk_pkg::sign_apply(corr_gain[rtk_pkg::CORR_W-1:0],
                                                     y_reg[rtk_pkg::ANGLE_W]));
                    phase_next = L_IDLE;
                end
            end
            default:
            begin
                phase_next = L_IDLE;
            end
        endcase
    end

    rtk_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= L_IDLE;
            angle_reg <= '0;
            rate_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            angle_reg <= angle_next;
            rate_reg  <= rate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg <= meas_next;
        xp_reg   <= xp_next;
        y_reg    <= y_next;
        k1_reg   <= k1_next;
    end

    assign sts.busy = (phase_reg != L_IDLE);
    assign angle    = angle_reg;

endmodule

// ===== rtl/rtk_merge.sv =====
// Merge stage: gathers the three lane angles and the count into the result register.
module rtk_merge
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               post,
    input  logic signed [rtk_pkg::ANGLE_W-1:0] angle_x,
    input  logic signed [rtk_pkg::ANGLE_W-1:0] angle_y,
    input  logic signed [rtk_pkg::ANGLE_W-1:0] angle_z,
    input  logic [rtk_pkg::COUNT_W-1:0]        count,
    output logic                               free,
    rtk_out_if.source                          res
);

    logic                               valid_reg, valid_next;
    logic signed [rtk_pkg::ANGLE_W-1:0] fx_reg, fy_reg, fz_reg;
    logic [rtk_pkg::COUNT_W-1:0]        cnt_reg;

    assign free = !valid_reg || res.ready;

    // Hold the result until the transaction completes
    always_comb
    begin
        valid_next = valid_reg;
        if (post)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (post)
        begin
            fx_reg  <= angle_x;
            fy_reg  <= angle_y;
            fz_reg  <= angle_z;
            cnt_reg <= count;
        end
    end

    assign res.valid      = valid_reg;
    assign res.filt_x     = fx_reg;
    assign res.filt_y     = fy_reg;
    assign res.filt_z     = fz_reg;
    assign res.seen_count = cnt_reg;

endmodule

// ===== rtl/rotation_kalman_tracker_core.sv =====
// Top level of the three-axis rotation Kalman tracker.
// Takes one timestamped rotation measurement at a time and returns one filtered result
// for each. The first measurement is echoed: it goes straight to posting. Every later
// one runs two covariance predictions on the shared multiplier, with a start state
// between them, a check of the innovation variance, and a gain division (one quotient
// bit a cycle, both gains at once). After that come a state to start the correction,
// three covariance corrections that run alongside the three axis lanes, and a post
// state. A zero innovation variance skips the division.
// A new measurement is taken on the cycle after a result is posted, while that result
// may still wait at the output. Posting waits for the output register to free.
// Registers are written over the cfg channel, which is always ready; index 3 is ignored.
module rotation_kalman_tracker_core
(
    input  logic       clk,
    input  logic       rst_n,
    rtk_in_if.sink     meas_in,
    rtk_out_if.source  filt_out,
    rtk_cfg_if.sink    cfg
);

    localparam int NLANE = 3;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_P01   = 11'b000_0000_0010,
        S_P00GO = 11'b000_0000_0100,
        S_P00   = 11'b000_0000_1000,
        S_SCHK  = 11'b000_0001_0000,
        S_DIV   = 11'b000_0010_0000,
        S_GAIN  = 11'b000_0100_0000,
        S_K00   = 11'b000_1000_0000,
        S_K01   = 11'b001_0000_0000,
        S_K11   = 11'b010_0000_0000,
        S_POST  = 11'b100_0000_0000
    } core_state_t;

    core_state_t                   state_reg, state_next;
    logic [rtk_pkg::COV_W-1:0]     q_noise_reg, r_noise_reg, init_cov_reg;
    logic                          started_reg, started_next;
    logic [rtk_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [rtk_pkg::TIME_W-1:0]    prev_time_reg, prev_time_next;
    logic [rtk_pkg::TIME_W-1:0]    dt_reg, dt_next, dt_in;
    logic [rtk_pkg::COV_W-1:0]     p00_reg, p00_next, p01_reg, p01_next, p11_reg, p11_next;
    logic [rtk_pkg::COV_W-1:0]     p00p_reg, p00p_next, p01p_reg, p01p_next;
    logic [rtk_pkg::COV_W-1:0]     p11p_reg, p11p_next;
    logic [rtk_pkg::COV_W-1:0]     k0_reg, k0_next, k1_reg, k1_next;

    logic                          accept, post, merge_free, lanes_busy;
    logic                          mul_start, mul_done, div_start, div_done;
    logic [rtk_pkg::MUL_A_W-1:0]   mul_a;
    logic [rtk_pkg::MUL_B_W-1:0]   mul_b;
    logic [rtk_pkg::PROD_W-1:0]    mul_prod;
    logic [rtk_pkg::COV_W-1:0]     prod_t, prod_g, div_q0, div_q1;
    logic [rtk_pkg::DIV_D_W-1:0]   s_sum;
    logic [rtk_pkg::COV_W:0]       sum49;
    logic [rtk_pkg::COV_W+1:0]     sum50;

    rtk_pkg::rtk_lane_ctl_t        lane_ctl;
    rtk_pkg::rtk_lane_sts_t        lane_sts [NLANE];
    logic signed [rtk_pkg::ANGLE_W-1:0] lane_meas  [NLANE];
    logic signed [rtk_pkg::ANGLE_W-1:0] lane_angle [NLANE];

    assign accept     = meas_in.valid && meas_in.ready;
    assign meas_in.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign dt_in      = meas_in.time_stamp - prev_time_reg;
    assign lanes_busy = lane_sts[0].busy || lane_sts[1].busy || lane_sts[2].busy;
    assign prod_t     = rtk_pkg::shr_sat(mul_prod, rtk_pkg::SH_TIME, rtk_pkg::MASK48);
    assign prod_g     = rtk_pkg::shr_sat(mul_prod, rtk_pkg::SH_GAIN, rtk_pkg::MASK48);
    assign s_sum      = rtk_pkg::DIV_D_W'(p00p_reg) + rtk_pkg::DIV_D_W'(r_noise_reg);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_noise_reg  <= rtk_pkg::PROC_NOISE_RST;
            r_noise_reg  <= rtk_pkg::MEAS_NOISE_RST;
            init_cov_reg <= rtk_pkg::INIT_COV_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                rtk_pkg::REG_PROCESS_NOISE:      q_noise_reg  <= cfg.data;
                rtk_pkg::REG_MEASURE_NOISE:      r_noise_reg  <= cfg.data;
                rtk_pkg::REG_INITIAL_COVARIANCE: init_cov_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Covariance sequencer
    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        count_next     = count_reg;
        prev_time_next = prev_time_reg;
        dt_next        = dt_reg;
        p00_next       = p00_reg;
        p01_next       = p01_reg;
        p11_next       = p11_reg;
        p00p_next      = p00p_reg;
        p01p_next      = p01p_reg;
        p11p_next      = p11p_reg;
        k0_next        = k0_reg;
        k1_next        = k1_reg;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        post           = 1'b0;
        lane_ctl       = '0;
        sum49          = '0;
        sum50          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg != rtk_pkg::COUNT_MAX)
                        count_next = count_reg + 1'b1;
                    prev_time_next = meas_in.time_stamp;
                    if (!started_reg)
                    begin
                        started_next   = 1'b1;
                        lane_ctl.first = 1'b1;
                        p00_next       = init_cov_reg;
                        p01_next       = '0;
                        p11_next       = init_cov_reg;
                        state_next     = S_POST;
                    end
                    else
                    begin
                        lane_ctl.capture = 1'b1;
                        dt_next    = dt_in;
                        mul_start  = 1'b1;
                        mul_a      = rtk_pkg::MUL_A_W'(dt_in);
                        mul_b      = p11_reg;
                        state_next = S_P01;
                    end
                end
            end
            S_P01:
            begin
                if (mul_done)
                begin
                    sum49      = (rtk_pkg::COV_W+1)'(p01_reg) + (rtk_pkg::COV_W+1)'(prod_t);
                    p01p_next  = sum49[rtk_pkg::COV_W] ? rtk_pkg::MASK48
                                                       : sum49[rtk_pkg::COV_W-1:0];
                    state_next = S_P00GO;
                end
            end
            S_P00GO:
            begin
                mul_start  = 1'b1;
                mul_a      = rtk_pkg::MUL_A_W'(p01_reg) + rtk_pkg::MUL_A_W'(p01p_reg);
                mul_b      = dt_reg;
                state_next = S_P00;
            end
            S_P00:
            begin
                if (mul_done)
                begin
                    sum50 = (rtk_pkg::COV_W+2)'(p00_reg) + (rtk_pkg::COV_W+2)'(prod_t)
                          + (rtk_pkg::COV_W+2)'(q_noise_reg);
                    p00p_next = (sum50 > (rtk_pkg::COV_W+2)'(rtk_pkg::MASK48))
                              ? rtk_pkg::MASK48 : sum50[rtk_pkg::COV_W-1:0];
                    sum49 = (rtk_pkg::COV_W+1)'(p11_reg) + (rtk_pkg::COV_W+1)'(q_noise_reg);
                    p11p_next  = sum49[rtk_pkg::COV_W] ? rtk_pkg::MASK48
                                                       : sum49[rtk_pkg::COV_W-1:0];
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                // Zero innovation variance: no correction
                if (s_sum == '0)
                begin
                    k0_next    = '0;
                    k1_next    = '0;
                    state_next = S_GAIN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    k0_next    = div_q0;
                    k1_next    = div_q1;
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                if (!lanes_busy)
                begin
                    lane_ctl.correct = 1'b1;
                    mul_start  = 1'b1;
                    mul_a      = rtk_pkg::MUL_A_W'(k0_reg);
                    mul_b      = p00p_reg;
                    state_next = S_K00;
                end
            end
            S_K00:
            begin
                if (mul_done)
                begin
                    p00_next   = p00p_reg - prod_g;
                    mul_start  = 1'b1;
                    mul_a      = rtk_pkg::MUL_A_W'(k0_reg);
                    mul_b      = p01p_reg;
                    state_next = S_K01;
                end
            end
            S_K01:
            begin
                if (mul_done)
                begin
                    p01_next   = p01p_reg - prod_g;
                    mul_start  = 1'b1;
                    mul_a      = rtk_pkg::MUL_A_W'(k1_reg);
                    mul_b      = p01p_reg;
                    state_next = S_K11;
                end
            end
            S_K11:
            begin
                if (mul_done)
                begin
                    // Clamp P11 at zero
                    p11_next   = (prod_g > p11p_reg) ? '0 : p11p_reg - prod_g;
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (merge_free && !lanes_busy)
                begin
                    post       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            count_reg     <= '0;
            prev_time_reg <= '0;
            p00_reg       <= rtk_pkg::INIT_COV_RST;
            p01_reg       <= '0;
            p11_reg       <= rtk_pkg::INIT_COV_RST;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            count_reg     <= count_next;
            prev_time_reg <= prev_time_next;
            p00_reg       <= p00_next;
            p01_reg       <= p01_next;
            p11_reg       <= p11_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg   <= dt_next;
        p00p_reg <= p00p_next;
        p01p_reg <= p01p_next;
        p11p_reg <= p11p_next;
        k0_reg   <= k0_next;
        k1_reg   <= k1_next;
    end

    rtk_mul u_cov_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    rtk_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n0    (p00p_reg),
        .n1    (p01p_reg),
        .d     (s_sum),
        .done  (div_done),
        .q0    (div_q0),
        .q1    (div_q1)
    );

    assign lane_meas[0] = meas_in.meas_x;
    assign lane_meas[1] = meas_in.meas_y;
    assign lane_meas[2] = meas_in.meas_z;

    // Axis lanes
    for (genvar gi = 0; gi < NLANE; gi++)
    begin : g_lane
        rtk_lane u_lane
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (lane_ctl),
            .meas  (lane_meas[gi]),
            .dt    (dt_in),
            .k0    (k0_reg),
            .k1    (k1_reg),
            .sts   (lane_sts[gi]),
            .angle (lane_angle[gi])
        );
    end

    rtk_merge u_merge
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .post    (post),
        .angle_x (lane_angle[0]),
        .angle_y (lane_angle[1]),
        .angle_z (lane_angle[2]),
        .count   (count_reg),
        .free    (merge_free),
        .res     (filt_out)
    );

    // A result is only posted into a free output register
    a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
        post |-> merge_free)
        else $error("result posted over an untaken result");

    // The count steps by one per accepted transaction and saturates
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg == (($past(count_reg) == rtk_pkg::COUNT_MAX)
                    ? rtk_pkg::COUNT_MAX : $past(count_reg) + 1'b1)))
        else $error("seen count out of step");

    // The angle gain never exceeds one
    a_k0_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GAIN) |-> (k0_reg <= rtk_pkg::CAP40))
        else $error("angle gain above unity");

    // Lanes are idle whenever a new transaction is taken
    a_lanes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !lanes_busy)
        else $error("lane busy at measurement acceptance");

endmodule

// ===== tb/tb_rotation_kalman_tracker_core.sv =====
// Self-checking testbench for the three-axis rotation Kalman tracker core.
`timescale 1ns / 100ps

module tb_rotation_kalman_tracker_core;

    localparam int  CLK_HALF   = 2;
    localparam int  RST_CYCLES = 9;
    localparam int  MAX_GAP    = 11;
    localparam int  RAND_ITEMS = 1330;
    localparam int  LONG_HOLD  = 600;
    localparam int  DRAIN_WAIT = 200;
    localparam longint CYCLE_LIMIT = 900000;
    localparam logic [rtk_pkg::IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [rtk_pkg::ANGLE_W-1:0] fx;
        logic signed [rtk_pkg::ANGLE_W-1:0] fy;
        logic signed [rtk_pkg::ANGLE_W-1:0] fz;
        logic [rtk_pkg::COUNT_W-1:0]        cnt;
    } filt_rec_t;

    // Tracker model and store of expected filtered angles
    class track_scoreboard;
        logic [rtk_pkg::COV_W-1:0]          q_noise;
        logic [rtk_pkg::COV_W-1:0]          r_noise;
        logic [rtk_pkg::COV_W-1:0]          p_init;
        bit                                 started;
        logic signed [rtk_pkg::ANGLE_W-1:0] angle[3];
        logic signed [rtk_pkg::ANGLE_W-1:0] rate[3];
        logic [63:0]                        p00, p01, p11;
        logic [rtk_pkg::TIME_W-1:0]         last_ts;
        logic [rtk_pkg::COUNT_W-1:0]        seen;
        filt_rec_t                          expected_q[$];
        int                                 mismatches;

        function void reset_state();
            q_noise    = rtk_pkg::PROC_NOISE_RST;
            r_noise    = rtk_pkg::MEAS_NOISE_RST;
            p_init     = rtk_pkg::INIT_COV_RST;
            started    = 0;
            foreach (angle[i])
            begin
                angle[i] = '0;
                rate[i]  = '0;
            end
            p00        = {16'b0, p_init};
            p01        = '0;
            p11        = {16'b0, p_init};
            last_ts    = '0;
            seen       = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [rtk_pkg::IDX_W-1:0] idx,
                                logic [rtk_pkg::COV_W-1:0] val);
            if (idx == rtk_pkg::REG_PROCESS_NOISE)
                q_noise = val;
            else if (idx == rtk_pkg::REG_MEASURE_NOISE)
                r_noise = val;
            else if (idx == rtk_pkg::REG_INITIAL_COVARIANCE)
                p_init = val;
        endfunction

        function logic [63:0] mul_cap(logic [63:0] a, logic [63:0] b, int sh,
                                      logic [63:0] cap);
            logic [127:0] p;
            p = ({64'b0, a} * {64'b0, b}) >> sh;
            if (p > {64'b0, cap})
                return cap;
            return p[63:0];
        endfunction

        function longint smul_cap(longint v, logic [63:0] k, int sh, logic [63:0] cap);
            logic [63:0] mag;
            longint      m;
            mag = (v < 0) ? -v : v;
            m   = mul_cap(mag, k, sh, cap);
            return (v < 0) ? -m : m;
        endfunction

        function logic [63:0] gain(logic [63:0] n, logic [63:0] d);
            logic [127:0] qt;
            qt = ({64'b0, n} << 40) / {64'b0, d};
            if (qt > 128'(rtk_pkg::MASK48))
                return {16'b0, rtk_pkg::MASK48};
            return qt[63:0];
        endfunction

        function logic [63:0] clamp48(logic [63:0] v);
            return (v > {16'b0, rtk_pkg::MASK48}) ? {16'b0, rtk_pkg::MASK48} : v;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // Advance the filter by one accepted measurement and queue its result
        function void note_meas(logic signed [rtk_pkg::ANGLE_W-1:0] m[3],
                                logic [rtk_pkg::TIME_W-1:0] ts);
            logic [rtk_pkg::TIME_W-1:0] dt;
            logic [63:0]                w48, p01p, p00p, p11p, s, k0, k1, mk;
            longint                     xp, y;
            filt_rec_t                  e;
            w48 = {16'b0, rtk_pkg::MASK48};
            if (seen != rtk_pkg::COUNT_MAX)
                seen = seen + 1'b1;
            if (!started)
            begin
                started = 1;
                foreach (angle[i])
                begin
                    angle[i] = m[i];
                    rate[i]  = '0;
                end
                p00     = {16'b0, p_init};
                p01     = '0;
                p11     = {16'b0, p_init};
                last_ts = ts;
            end
            else
            begin
                dt      = ts - last_ts;
                last_ts = ts;
                p01p = clamp48(p01 + mul_cap({16'b0, dt}, p11, 16, w48));
                p00p = clamp48(p00 + mul_cap({16'b0, dt}, p01 + p01p, 16, w48) + q_noise);
                p11p = clamp48(p11 + q_noise);
                s    = p00p + r_noise;
                k0   = '0;
                k1   = '0;
                if (s != 0)
                begin
                    k0 = gain(p00p, s);
                    k1 = gain(p01p, s);
                end
                foreach (angle[i])
                begin
                    xp = clamp32(longint'(angle[i]) +
                                 smul_cap(longint'(rate[i]), {16'b0, dt}, 16,
                                          rtk_pkg::CAP40));
                    y  = longint'(m[i]) - xp;
                    angle[i] = clamp32(xp + smul_cap(y, k0, 40, rtk_pkg::CAP40));
                    rate[i]  = clamp32(longint'(rate[i]) +
                                       smul_cap(y, k1, 40, rtk_pkg::CAP40));
                end
                p00 = p00p - mul_cap(k0, p00p, 40, w48);
                p01 = p01p - mul_cap(k0, p01p, 40, w48);
                mk  = mul_cap(k1, p01p, 40, w48);
                p11 = (mk > p11p) ? 64'd0 : p11p - mk;
            end
            e.fx  = angle[0];
            e.fy  = angle[1];
            e.fz  = angle[2];
            e.cnt = seen;
            expected_q.push_back(e);
        endfunction

        // Compare one delivered result with the oldest expectation
        function void check_result(filt_rec_t act);
            filt_rec_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d count=%0d",
                             act.fx, act.fy, act.fz, act.cnt);
                return;
            end
            e = expected_q.pop_front();
            if (act !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected x=%0d y=%0d z=%0d count=%0d,",
                              " got x=%0d y=%0d z=%0d count=%0d"},
                             e.fx, e.fy, e.fz, e.cnt, act.fx, act.fy, act.fz, act.cnt);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    longint cycles;
    bit     hold_req;
    logic signed [rtk_pkg::ANGLE_W-1:0] track_ang[3];
    logic [rtk_pkg::TIME_W-1:0]         track_ts;
    track_scoreboard                    sb;

    rtk_in_if  meas_if();
    rtk_out_if filt_if();
    rtk_cfg_if cfg_if();

    rotation_kalman_tracker_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .meas_in  (meas_if),
        .filt_out (filt_if),
        .cfg      (cfg_if)
    );

    // Clock
    initial
    begin
        clk = 0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("rotation_kalman_tracker_core verification failed");
                $finish;
            end
        end
    end

    // Observe transactions on every channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
                sb.write_reg(cfg_if.index, cfg_if.data);
            if (meas_if.valid && meas_if.ready)
                sb.note_meas('{meas_if.meas_x, meas_if.meas_y, meas_if.meas_z},
                             meas_if.time_stamp);
            if (filt_if.valid && filt_if.ready)
                sb.check_result({filt_if.filt_x, filt_if.filt_y, filt_if.filt_z,
                                 filt_if.seen_count});
        end
    end

    // Result side: random stalls, bursts with none, one long hold-off on request
    initial
    begin
        int stall;
        int burst;
        bit hold_done;
        filt_if.ready <= 1'b0;
        burst = 0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                filt_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1;
            end
            if (burst > 0)
            begin
                burst--;
                stall = 0;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                burst = $urandom_range(10, 40);
                stall = 0;
            end
            else
                stall = $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                filt_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            filt_if.ready <= 1'b1;
            do @(posedge clk); while (!filt_if.valid);
        end
    end

    task automatic write_cfg(logic [rtk_pkg::IDX_W-1:0] idx, logic [rtk_pkg::COV_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_meas(logic signed [rtk_pkg::ANGLE_W-1:0] mx,
                             logic signed [rtk_pkg::ANGLE_W-1:0] my,
                             logic signed [rtk_pkg::ANGLE_W-1:0] mz,
                             logic [rtk_pkg::TIME_W-1:0] ts, int gap);
        if (gap > 0)
        begin
            meas_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        meas_if.valid      <= 1'b1;
        meas_if.meas_x     <= mx;
        meas_if.meas_y     <= my;
        meas_if.meas_z     <= mz;
        meas_if.time_stamp <= ts;
        do @(posedge clk); while (!meas_if.ready);
    endtask

    // Wait until every expected result has come, with the input lowered
    task automatic drain();
        meas_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [rtk_pkg::COV_W-1:0] pick_cfg();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return rtk_pkg::MASK48;
            2: return 48'($urandom_range(0, 4096)) << $urandom_range(0, 40);
            3: return 48'({$urandom, $urandom});
            default: return 48'($urandom_range(1, 1 << 20)) << $urandom_range(10, 30);
        endcase
    endfunction

    function automatic logic [rtk_pkg::TIME_W-1:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // Random measurement: mostly a smooth track, some noise and odd time steps
    task automatic send_random(int gap_mode);
        int   kind;
        int   gap;
        logic signed [rtk_pkg::ANGLE_W-1:0] m[3];
        kind = $urandom_range(0, 19);
        gap  = gap_mode ? $urandom_range(0, MAX_GAP) : 0;
        if (kind < 2)
        begin
            foreach (m[i])
                m[i] = $urandom;
            track_ts = rand48();
        end
        else
        begin
            if (kind == 2)
                track_ts = track_ts - 48'($urandom_range(1, 1 << 16));
            else if (kind == 3)
                track_ts = track_ts + {$urandom, 16'h0};
            else
                track_ts = track_ts + 48'($urandom_range(0, 8192));
            foreach (m[i])
            begin
                track_ang[i] = track_ang[i] + $signed(32'($urandom_range(0, 1 << 20))) -
                               32'sd524288;
                m[i] = track_ang[i] + $signed(32'($urandom_range(0, 1 << 16))) - 32'sd32768;
            end
        end
        send_meas(m[0], m[1], m[2], track_ts, gap);
    endtask

    // Stimulus
    initial
    begin
        sb = new();
        sb.reset_state();
        hold_req = 0;
        rst_n <= 1'b0;
        meas_if.valid      <= 1'b0;
        meas_if.meas_x     <= '0;
        meas_if.meas_y     <= '0;
        meas_if.meas_z     <= '0;
        meas_if.time_stamp <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero covariance and noise: first item echo, then zero innovation variance
        write_cfg(rtk_pkg::REG_PROCESS_NOISE, '0);
        write_cfg(rtk_pkg::REG_MEASURE_NOISE, '0);
        write_cfg(rtk_pkg::REG_INITIAL_COVARIANCE, '0);
        send_meas(32'sh7FFFFFFF, 32'sh80000000, -32'sd1, 48'd0, 0);
        send_meas(32'sh80000000, 32'sh7FFFFFFF, 32'sd0, 48'd0, 1);
        send_meas(32'sd0, -32'sd1, 32'sh7FFFFFFF, 48'd1, 0);
        send_meas(32'sh12345678, 32'shEDCBA987, 32'sh55555555, rtk_pkg::MASK48, 2);
        drain();

        // Largest settings: saturating covariance, time going backwards
        write_cfg(rtk_pkg::REG_PROCESS_NOISE, rtk_pkg::MASK48);
        write_cfg(rtk_pkg::REG_MEASURE_NOISE, rtk_pkg::MASK48);
        write_cfg(rtk_pkg::REG_INITIAL_COVARIANCE, rtk_pkg::MASK48);
        write_cfg(REG_SPARE, 48'hABCDEF012345);
        send_meas(32'sh2AAAAAAA, 32'shD5555555, 32'sh7FFFFFFF, 48'h000000010000, 0);
        send_meas(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 48'h0000000000FF, 0);
        send_meas(32'sh7FFFFFFF, 32'sh80000000, 32'sh00000001, rtk_pkg::MASK48, 3);
        send_meas(32'sh00000000, 32'sh00000000, 32'sh00000000, 48'h800000000000, 0);
        drain();

        // Small measurement noise with large process noise: gains near one
        write_cfg(rtk_pkg::REG_MEASURE_NOISE, 48'd1);
        write_cfg(rtk_pkg::REG_PROCESS_NOISE, 48'h010000000000);
        send_meas(32'sh01000000, -32'sh01000000, 32'sh00800000, 48'h000000810000, 0);
        send_meas(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 48'h000000820000, 0);
        send_meas(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 48'h000000830000, 0);
        drain();

        // Reset-like settings for a smooth track
        write_cfg(rtk_pkg::REG_PROCESS_NOISE, rtk_pkg::PROC_NOISE_RST);
        write_cfg(rtk_pkg::REG_MEASURE_NOISE, rtk_pkg::MEAS_NOISE_RST);
        write_cfg(rtk_pkg::REG_INITIAL_COVARIANCE, rtk_pkg::INIT_COV_RST);
        track_ts = 48'h000001000000;
        foreach (track_ang[i])
            track_ang[i] = '0;
        for (int n = 0; n < 8; n++)
            send_random(1);
        drain();

        // Random part, with a new setting every few hundred items
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 120)
                hold_req = 1;
            if (n == 700)
                drain();
            if (n % 250 == 249)
            begin
                drain();
                write_cfg(rtk_pkg::REG_PROCESS_NOISE, pick_cfg());
                write_cfg(rtk_pkg::REG_MEASURE_NOISE, pick_cfg());
                write_cfg(rtk_pkg::REG_INITIAL_COVARIANCE, pick_cfg());
            end
            send_random(((n / 60) % 3) != 0);
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("rotation_kalman_tracker_core verification clean");
        else
            $display("rotation_kalman_tracker_core verification failed");
        $finish;
    end

endmodule
